[hw/rtl/lprl_pkg.sv]
// Shared types and constants for the longest prefix route lookup block.
`timescale 1ns / 1ps
`default_nettype none

package lprl_pkg;

  // Fixed field widths of the streaming interface.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned IDX_OUT_W  = 10;
  localparam int unsigned PORT_OUT_W = 4;
  localparam int unsigned CFG_W      = 11;

  // Input mode codes carried in in_tuser.
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Bit offsets of the fields inside one stored route word.
  localparam int unsigned WORD_PREFIX_LSB = 0;
  localparam int unsigned WORD_MASK_LSB   = 32;
  localparam int unsigned WORD_HOP_LSB    = 64;
  localparam int unsigned WORD_PORT_LSB   = 96;

  // Scan engine states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } lprl_state_t;

  // Lookup request from the front end to the scan engine.
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] addr;
  } lprl_req_t;

  // Finished lookup handed from the scan engine to the output register.
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [IDX_OUT_W-1:0]  match_index;
    logic [ADDR_W-1:0]     gateway;
    logic [PORT_OUT_W-1:0] port;
  } lprl_result_t;

endpackage

`default_nettype wire

[hw/rtl/longest_prefix_route_lookup_top.sv]
// Top level of the longest prefix route lookup block.
//
//  Channel  Direction  Handshake          Contents
//  in_      slave      tvalid / tready    tuser: mode; tdata: route entry or destination
//  out_     master     tvalid / tready    tuser: hit; tdata: index, next hop, port
//  cfg_     write only wr_en              entries_in_use
//
// A write transaction stores one table entry.
// A lookup transaction scans entries_in_use entries, at most the table depth: the scan
// engine reads one entry per cycle from the route memory; its one read port sets the rate.
// New transactions are taken only while the scan engine is idle; a finished result
// waits in the output register, and the engine holds it while res_ready is low.
// Reset (rst_n, synchronous) clears control state; table entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_lookup_top #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned PORT_BITS   = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // tdata: entry_index[9:0], entry_prefix[41:10], entry_mask[73:42],
  //        entry_gateway[105:74], entry_port[109:106], lookup_addr[141:110], zero[143:142]
  input  wire logic [143:0] in_tdata,
  // tuser: mode[0]
  input  wire logic [0:0]   in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: match_index[9:0], gateway[41:10], port[45:42], zero[47:46]
  output logic      [47:0]  out_tdata,
  // tuser: hit[0]
  output logic      [0:0]   out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_wr_en,
  input  wire logic [10:0]  cfg_wr_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > lprl_pkg::CFG_W) ? CNT_W : lprl_pkg::CFG_W;
  localparam int unsigned DW    = lprl_pkg::WORD_PORT_LSB + PORT_BITS;

  logic [lprl_pkg::CFG_W-1:0] entries_r;
  logic [CMP_W-1:0]           entries_ext;
  logic [CNT_W-1:0]           scan_count;

  logic                   in_acc;
  logic [9:0]             f_index;
  logic [31:0]            f_prefix;
  logic [31:0]            f_mask;
  logic [31:0]            f_hop;
  logic [3:0]             f_port;
  logic [31:0]            f_addr;

  logic                   wr_en;
  logic [DW-1:0]          wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [DW-1:0]          rd_data;

  lprl_pkg::lprl_req_t    req;
  lprl_pkg::lprl_result_t res;
  logic                   scan_idle;
  logic                   res_ready;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [9:0]             out_idx_r;
  logic [31:0]            out_hop_r;
  logic [3:0]             out_port_r;

  // Unpack the input transaction.
  assign f_index  = in_tdata[9:0];
  assign f_prefix = in_tdata[41:10];
  assign f_mask   = in_tdata[73:42];
  assign f_hop    = in_tdata[105:74];
  assign f_port   = in_tdata[109:106];
  assign f_addr   = in_tdata[141:110];

  assign in_tready = scan_idle;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  // Entry count saturated to the table depth.
  assign entries_ext = CMP_W'(entries_r);
  assign scan_count  = (entries_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(entries_ext);

  // Route writes; an index beyond the table is dropped.
  assign wr_en   = in_acc && (in_tuser[0] == lprl_pkg::MODE_WRITE) &&
                   (32'(f_index) < 32'(TABLE_DEPTH));
  assign wr_data = {PORT_BITS'(f_port), f_hop, f_mask, f_prefix};

  // Lookup request.
  assign req.start = in_acc && (in_tuser[0] == lprl_pkg::MODE_LOOKUP);
  assign req.addr  = f_addr;

  lprl_route_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (IDX_W'(f_index)),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  lprl_scan #(
    .PORT_BITS (PORT_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W),
    .DW        (DW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .count     (scan_count),
    .idle      (scan_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register takes a result when empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_hit_r  <= res.hit;
      out_idx_r  <= res.match_index;
      out_hop_r  <= res.gateway;
      out_port_r <= res.port;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {2'b00, out_port_r, out_hop_r, out_idx_r};

  // A lookup occupies the engine, so the next cycle takes no transaction.
  a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == lprl_pkg::MODE_LOOKUP)) |=> !in_tready)
    else $error("input accepted right after a lookup");

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("miss result with nonzero fields");

  // The output register fills only from a finished scan.
  a_load_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res.valid))
    else $error("result appeared without a finished scan");

endmodule

`default_nettype wire

[hw/rtl/lprl_route_mem.sv]
// Route table memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lprl_route_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 100
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lprl_scan.sv]
// Scan engine: walks the route table one entry per cycle and keeps the best match.
`timescale 1ns / 1ps
`default_nettype none

module lprl_scan #(
  parameter int unsigned PORT_BITS = 4,
  parameter int unsigned IDX_W     = 10,
  parameter int unsigned CNT_W     = 11,
  parameter int unsigned DW        = 100
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lprl_pkg::lprl_req_t    req,
  input  wire logic       [CNT_W-1:0] count,
  output logic                        idle,
  output logic                        rd_en,
  output logic            [IDX_W-1:0] rd_addr,
  input  wire logic          [DW-1:0] rd_data,
  output lprl_pkg::lprl_result_t      res,
  input  wire logic                   res_ready
);

  lprl_pkg::lprl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              issue_last;
  logic              rd_vld_r;
  logic              rd_last_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [31:0]       addr_r;
  logic              found_r;
  logic [31:0]       best_mask_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [31:0]       best_hop_r;
  logic [PORT_BITS-1:0] best_port_r;

  logic [31:0]          ent_prefix;
  logic [31:0]          ent_mask;
  logic [31:0]          ent_hop;
  logic [PORT_BITS-1:0] ent_port;
  logic                 take;

  // Unpack the entry that came back from the memory.
  assign ent_prefix = rd_data[lprl_pkg::WORD_PREFIX_LSB +: 32];
  assign ent_mask   = rd_data[lprl_pkg::WORD_MASK_LSB +: 32];
  assign ent_hop    = rd_data[lprl_pkg::WORD_HOP_LSB +: 32];
  assign ent_port   = rd_data[lprl_pkg::WORD_PORT_LSB +: PORT_BITS];

  // A matching entry replaces the best one when its mask is numerically no smaller.
  assign take = rd_vld_r && ((addr_r & ent_mask) == ent_prefix) &&
                (!found_r || (ent_mask >= best_mask_r));

  // Next state and read issue.
  always_comb begin
    state_nxt  = state_r;
    iss_nxt    = iss_r;
    rd_en      = 1'b0;
    rd_addr    = iss_r[IDX_W-1:0];
    issue_last = 1'b0;
    case (state_r)
      lprl_pkg::ST_IDLE: begin
        if (req.start) begin
          iss_nxt   = '0;
          state_nxt = (count == '0) ? lprl_pkg::ST_DONE : lprl_pkg::ST_RUN;
        end
      end
      lprl_pkg::ST_RUN: begin
        if (iss_r < count) begin
          rd_en      = 1'b1;
          iss_nxt    = iss_r + CNT_W'(1);
          issue_last = ((iss_r + CNT_W'(1)) == count);
        end
        if (rd_vld_r && rd_last_r) begin
          state_nxt = lprl_pkg::ST_DONE;
        end
      end
      lprl_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = lprl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lprl_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lprl_pkg::ST_IDLE;
      iss_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_r     <= iss_nxt;
      rd_vld_r  <= rd_en;
      rd_last_r <= issue_last;
      if (state_r == lprl_pkg::ST_IDLE && req.start) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  // Payload registers: lookup address, read tag and best entry so far.
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr;
    if (state_r == lprl_pkg::ST_IDLE && req.start) begin
      addr_r <= req.addr;
    end
    if (take) begin
      best_mask_r <= ent_mask;
      best_idx_r  <= rd_idx_r;
      best_hop_r  <= ent_hop;
      best_port_r <= ent_port;
    end
  end

  // Result; a miss reports zeros.
  always_comb begin
    res.valid       = (state_r == lprl_pkg::ST_DONE);
    res.hit         = found_r;
    res.match_index = found_r ? lprl_pkg::IDX_OUT_W'(best_idx_r) : '0;
    res.gateway     = found_r ? best_hop_r : '0;
    res.port        = found_r ? lprl_pkg::PORT_OUT_W'(best_port_r) : '0;
  end

  assign idle = (state_r == lprl_pkg::ST_IDLE);

endmodule

`default_nettype wire

[dv/tb_longest_prefix_route_lookup_top.sv]
// Self-checking testbench for the longest prefix route lookup block, with its own route predictor.
`timescale 1ns / 1ps

module tb_longest_prefix_route_lookup_top;

  localparam int unsigned     DEPTH        = 1024;
  localparam int unsigned     RANDOM_ITEMS = 560;
  localparam int unsigned     HOLD_CYCLES  = 300;
  localparam int unsigned     MAX_SHOWN    = 10;
  localparam int unsigned     NUM_ROWS     = 23;
  localparam longint unsigned CYCLE_LIMIT  = 400000;

  // One route table entry as stored by a write transaction.
  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  port;
  } route_entry_t;

  // One lookup result as carried on the result channel.
  typedef struct packed {
    logic        hit;
    logic [9:0]  match_index;
    logic [31:0] gateway;
    logic [3:0]  port;
  } route_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_LOOKUP,
    ROW_COUNT
  } row_kind_t;

  // One row of the directed stimulus table.
  typedef struct packed {
    row_kind_t     kind;
    logic [9:0]    index;
    route_entry_t  entry;
    logic [31:0]   addr;
    logic [10:0]   count;
    logic          fixed;
    route_result_t fixed_result;
  } stim_row_t;

  localparam route_result_t NO_ROUTE = '0;

  logic         clk = 1'b0;
  logic         rst_n;
  logic [143:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_wr_en;
  logic [10:0]  cfg_wr_data;

  // Predicted state of the block.
  logic [31:0] rt_prefix   [DEPTH];
  logic [31:0] rt_mask     [DEPTH];
  logic [31:0] rt_gateway  [DEPTH];
  logic [3:0]  rt_port     [DEPTH];
  bit          written     [DEPTH];
  logic [10:0] route_count;

  route_result_t   expected_routes[$];
  logic [31:0]     net_pool[4];
  stim_row_t       directed[NUM_ROWS];
  bit              no_idle;
  int unsigned     fail_count;
  longint unsigned cycle_count;

  longest_prefix_route_lookup_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Number of entries a lookup scans; larger counts saturate at the table depth.
  function automatic int unsigned searched_entries();
    return (route_count > DEPTH) ? DEPTH : int'(route_count);
  endfunction

  // Longest mask wins, compared as a number; ties go to the highest index.
  function automatic route_result_t route_lookup(logic [31:0] addr);
    route_result_t res;
    logic [31:0]   best_mask;
    int unsigned   limit;
    res = NO_ROUTE;
    best_mask = '0;
    limit = searched_entries();
    for (int unsigned i = 0; i < limit; i++) begin
      if ((addr & rt_mask[i]) == rt_prefix[i] && (!res.hit || rt_mask[i] >= best_mask)) begin
        res.hit = 1'b1;
        res.match_index = 10'(i);
        best_mask = rt_mask[i];
      end
    end
    if (res.hit) begin
      res.gateway = rt_gateway[res.match_index];
      res.port = rt_port[res.match_index];
    end
    return res;
  endfunction

  // Random entry: mostly a contiguous mask over a shared network, so that routes nest.
  function automatic route_entry_t make_route();
    route_entry_t e;
    int unsigned  len;
    len = $urandom_range(0, 32);
    e.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    if ($urandom_range(0, 9) == 0) e.mask = $urandom;
    e.prefix = net_pool[$urandom_range(0, 3)] & e.mask;
    if ($urandom_range(0, 9) == 0) e.prefix = $urandom;
    e.gateway = $urandom;
    e.port = 4'($urandom_range(0, 15));
    return e;
  endfunction

  // Destination mostly inside a searched route, otherwise near a network or fully random.
  function automatic logic [31:0] pick_addr();
    int unsigned limit;
    int unsigned j;
    logic [31:0] noise;
    limit = searched_entries();
    noise = $urandom;
    if (limit != 0 && $urandom_range(0, 3) != 0) begin
      j = $urandom_range(0, limit - 1);
      return (rt_prefix[j] & rt_mask[j]) | (noise & ~rt_mask[j]);
    end
    if ($urandom_range(0, 1) == 1) return net_pool[$urandom_range(0, 3)] ^ (noise >> $urandom_range(0, 31));
    return noise;
  endfunction

  function automatic stim_row_t write_row(logic [9:0] index, logic [31:0] prefix,
                                          logic [31:0] mask, logic [31:0] hop, logic [3:0] port);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = index;
    r.entry = '{prefix: prefix, mask: mask, gateway: hop, port: port};
    return r;
  endfunction

  function automatic stim_row_t lookup_row(logic [31:0] addr, logic fixed, route_result_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_LOOKUP;
    r.addr = addr;
    r.fixed = fixed;
    r.fixed_result = want;
    return r;
  endfunction

  function automatic stim_row_t count_row(logic [10:0] count);
    stim_row_t r;
    r = '0;
    r.kind = ROW_COUNT;
    r.count = count;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%s", msg);
  endtask

  // Offer one transaction after a random gap and return at the edge that accepts it.
  task automatic offer_item(input logic mode, input logic [143:0] data);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_write(input logic [9:0] index, input route_entry_t e);
    logic [31:0] junk_addr;
    junk_addr = $urandom;
    offer_item(lprl_pkg::MODE_WRITE,
               {2'b00, junk_addr, e.port, e.gateway, e.mask, e.prefix, index});
    rt_prefix[index]  = e.prefix;
    rt_mask[index]    = e.mask;
    rt_gateway[index] = e.gateway;
    rt_port[index]    = e.port;
    written[index]    = 1'b1;
  endtask

  task automatic send_lookup(input logic [31:0] addr, input logic fixed, input route_result_t want);
    route_entry_t junk;
    logic [9:0]   junk_index;
    junk = make_route();
    junk_index = 10'($urandom_range(0, DEPTH - 1));
    offer_item(lprl_pkg::MODE_LOOKUP,
               {2'b00, addr, junk.port, junk.gateway, $urandom, $urandom, junk_index});
    expected_routes.push_back(fixed ? want : route_lookup(addr));
  endtask

  // The register changes only once the block has drained and finished any scan.
  task automatic set_route_count(input logic [10:0] value);
    in_tvalid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (searched_entries() + 8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    route_count = value;
  endtask

  // Result receiver: random stalls, two long hold-offs, and stall-free stretches.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    out_tready = 1'b0;
    forever begin
      if (taken == 30 || taken == 200) stall = HOLD_CYCLES;
      else stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Compare each result transaction with the oldest expected route.
  always @(posedge clk) begin : result_check
    route_result_t got;
    route_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[9:0], out_tdata[41:10], out_tdata[45:42]};
      if (expected_routes.size() == 0) begin
        note_failure($sformatf("Unexpected result: hit=%0d index=%0d gateway=%h port=%0d",
                               got.hit, got.match_index, got.gateway, got.port));
      end else begin
        want = expected_routes.pop_front();
        if (got.hit !== want.hit || got.match_index !== want.match_index ||
            got.gateway !== want.gateway || got.port !== want.port) begin
          note_failure($sformatf({"Mismatch: expected hit=%0d index=%0d gateway=%h port=%0d,",
                                  " got hit=%0d index=%0d gateway=%h port=%0d"},
                                 want.hit, want.match_index, want.gateway, want.port,
                                 got.hit, got.match_index, got.gateway, got.port));
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [10:0] count;
    logic [9:0]  index;
    int unsigned limit;
    int unsigned sent;
    int unsigned burst;

    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    in_tvalid   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    no_idle     = 1'b0;
    fail_count  = 0;
    route_count = '0;
    for (int unsigned i = 0; i < DEPTH; i++) written[i] = 1'b0;
    foreach (net_pool[k]) net_pool[k] = $urandom;

    // Directed table: empty table, default route, nested masks, a tie,
    // a non-contiguous mask, an entry that never matches, and an overwrite.
    directed[0]  = lookup_row(32'h0000_0000, 1'b1, NO_ROUTE);
    directed[1]  = lookup_row(32'hFFFF_FFFF, 1'b1, NO_ROUTE);
    directed[2]  = write_row(10'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF);
    directed[3]  = write_row(10'd1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'h1);
    directed[4]  = write_row(10'd2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'h2);
    directed[5]  = write_row(10'd3, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_02FE, 4'h3);
    directed[6]  = write_row(10'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0);
    directed[7]  = write_row(10'd5, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_0201, 4'h5);
    directed[8]  = write_row(10'd6, 32'h0012_0034, 32'h00FF_00FF, 32'h0012_0001, 4'h6);
    directed[9]  = write_row(10'd7, 32'h0000_0001, 32'h0000_0000, 32'h1111_1111, 4'h7);
    directed[10] = count_row(11'd8);
    directed[11] = lookup_row(32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd4, 32'h0, 4'h0});
    directed[12] = lookup_row(32'h0A01_0203, 1'b0, NO_ROUTE);
    directed[13] = lookup_row(32'h0A01_FF00, 1'b0, NO_ROUTE);
    directed[14] = lookup_row(32'h0A7F_0000, 1'b0, NO_ROUTE);
    directed[15] = lookup_row(32'h0B00_0000, 1'b0, NO_ROUTE);
    directed[16] = lookup_row(32'h7F12_0034, 1'b0, NO_ROUTE);
    directed[17] = lookup_row(32'h0000_0000, 1'b0, NO_ROUTE);
    directed[18] = count_row(11'd1);
    directed[19] = lookup_row(32'h1234_5678, 1'b0, NO_ROUTE);
    directed[20] = write_row(10'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 4'h0);
    directed[21] = lookup_row(32'h0B00_0000, 1'b1, NO_ROUTE);
    directed[22] = lookup_row(32'h0AFF_FFFF, 1'b0, NO_ROUTE);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) begin
      case (directed[r].kind)
        ROW_WRITE:  send_write(directed[r].index, directed[r].entry);
        ROW_LOOKUP: send_lookup(directed[r].addr, directed[r].fixed, directed[r].fixed_result);
        default:    set_route_count(directed[r].count);
      endcase
    end

    // Random phases; each phase first writes any entry it will search.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      count = ($urandom_range(0, 7) == 0) ? 11'd0 : 11'($urandom_range(1, 48));
      limit = (count > DEPTH) ? DEPTH : int'(count);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < limit; i++) begin
        if (!written[i]) begin
          send_write(10'(i), make_route());
          sent++;
        end
      end
      set_route_count(count);
      burst = $urandom_range(15, 40);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 7) begin
          send_lookup(pick_addr(), 1'b0, NO_ROUTE);
        end else begin
          if (limit != 0 && $urandom_range(0, 3) != 0) index = 10'($urandom_range(0, limit - 1));
          else index = 10'($urandom_range(0, DEPTH - 1));
          send_write(index, make_route());
        end
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (searched_entries() + 16) @(posedge clk);
    if (fail_count == 0 && expected_routes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lprl_pkg.sv
hw/rtl/lprl_route_mem.sv
hw/rtl/lprl_scan.sv
hw/rtl/longest_prefix_route_lookup_top.sv
dv/tb_longest_prefix_route_lookup_top.sv
